@@ rtl/xpm_image_decoder_core_defines.svh @@
// Assertion macros used by the checker file.
`ifndef XPM_IMAGE_DECODER_CORE_DEFINES_SVH
`define XPM_IMAGE_DECODER_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define XID_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define XID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/xid_pkg.sv @@
`default_nettype none
package xid_pkg;
  localparam int MaxColors   = 256;
  localparam int ColorIdxW   = 8;
  localparam int ColorCntW   = 9;
  localparam int MaxKeyChars = 2;
  localparam int MaxDim      = 1024;
  localparam int DimW        = 11;
  localparam int PosW        = 12;
  localparam int KeyW        = 16;
  localparam logic [PosW-1:0] PosMax = 12'hFFF;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_COLORS = 2'd1,
    PH_PIXELS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic step;        // process the accepted item
    logic search_clr;  // reset search index
    logic search_inc;  // advance search index
    logic emit;        // load output register from current entry
  } xid_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic need_search; // item closes a key group inside the row
    logic hit;         // current table entry matches
    logic search_end;  // current index is the last valid entry
  } xid_sts_t;
endpackage
`default_nettype wire

@@ rtl/xid_datapath.sv @@
`default_nettype none
module xid_datapath (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire  [0:0]          cfg_index,
  input  wire  [11:0]         cfg_wdata,
  input  wire  [7:0]          char_byte,
  input  wire                 line_end,
  input  wire                 image_start,
  input  xid_pkg::xid_cmd_t   cmd,
  output xid_pkg::xid_sts_t   sts,
  output logic signed [12:0]  pixel_x,
  output logic signed [12:0]  pixel_y,
  output logic [31:0]         pixel_color,
  output logic                last_pixel
);
  logic signed [11:0] origin_x_r, origin_y_r;
  xid_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  hidx_r, hidx_nxt;
  logic [15:0] dec_r, dec_nxt;
  logic [xid_pkg::DimW-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [xid_pkg::DimW-1:0] lcnt_r, lcnt_nxt;
  logic [xid_pkg::ColorCntW-1:0] ccnt_r, ccnt_nxt;
  logic [1:0]  klen_r, klen_nxt;
  logic [xid_pkg::PosW-1:0] pos_r, pos_nxt;
  logic [xid_pkg::KeyW-1:0] kacc_r, kacc_nxt;
  logic [31:0] hex_r, hex_nxt;
  logic        hdone_r, hdone_nxt;
  logic [2:0]  kfill_r, kfill_nxt;
  logic [xid_pkg::PosW-1:0] xsrch_r;
  logic [xid_pkg::KeyW-1:0] ksrch_r;
  logic [xid_pkg::DimW-1:0] ysrch_r;
  logic [xid_pkg::ColorIdxW-1:0] sidx_r;
  logic [xid_pkg::KeyW-1:0] key_mem [xid_pkg::MaxColors];
  logic [31:0] col_mem [xid_pkg::MaxColors];
  logic [xid_pkg::KeyW-1:0] key_rd;
  logic [31:0] col_rd;
  logic        tbl_we;
  logic [xid_pkg::ColorIdxW-1:0] tbl_wa;
  logic [xid_pkg::KeyW-1:0] key_wr;
  logic [31:0] hex_wr;
  logic [xid_pkg::ColorIdxW-1:0] raddr;
  logic        need_search;
  logic        rd_ok_r;

  // Helpers for the header, color and pixel fields.
  logic        is_digit;
  logic [19:0] dec_mul;
  logic [1:0]  cpp;
  logic [3:0]  hexd;
  logic        hexok;
  logic [2:0]  kfill_inc;

  assign is_digit = (char_byte >= 8'd48) && (char_byte <= 8'd57);
  assign dec_mul  = {4'd0, dec_r} * 20'd10 + {12'd0, char_byte - 8'd48};
  assign cpp      = (klen_r == 2'd0) ? 2'd1 : klen_r;

  always_comb begin
    hexok = 1'b1;
    hexd  = 4'd0;
    if (char_byte >= 8'd48 && char_byte <= 8'd57) hexd = 4'(char_byte - 8'd48);
    else if (char_byte >= 8'd97 && char_byte <= 8'd102) hexd = 4'(char_byte - 8'd87);
    else if (char_byte >= 8'd65 && char_byte <= 8'd70) hexd = 4'(char_byte - 8'd55);
    else hexok = 1'b0;
  end

  assign kfill_inc   = kfill_r + 3'd1;
  assign need_search = (phase_r == xid_pkg::PH_PIXELS) && !image_start &&
                       (kfill_inc >= {1'b0, cpp}) &&
                       ({1'b0, pos_r} < {2'b0, width_r}) && (ccnt_r != '0);

  // Per-item state update, mirroring the line parser.
  always_comb begin
    logic [2:0] fidx;
    logic [15:0] fv;
    phase_nxt = phase_r; hidx_nxt = hidx_r; dec_nxt = dec_r;
    width_nxt = width_r; height_nxt = height_r; ccnt_nxt = ccnt_r;
    klen_nxt = klen_r; lcnt_nxt = lcnt_r; pos_nxt = pos_r;
    kacc_nxt = kacc_r; hex_nxt = hex_r; hdone_nxt = hdone_r; kfill_nxt = kfill_r;
    tbl_we = 1'b0; tbl_wa = lcnt_r[xid_pkg::ColorIdxW-1:0];
    key_wr = kacc_r; hex_wr = hex_r;
    fidx = 3'd0; fv = 16'd0;
    if (image_start) begin
      phase_nxt = xid_pkg::PH_HEADER; hidx_nxt = '0; dec_nxt = '0;
      width_nxt = '0; height_nxt = '0; ccnt_nxt = '0; klen_nxt = '0;
      lcnt_nxt = '0; pos_nxt = '0; kacc_nxt = '0; hex_nxt = '0;
      hdone_nxt = 1'b0; kfill_nxt = '0;
    end
    unique case (image_start ? xid_pkg::PH_HEADER : phase_r)
      xid_pkg::PH_HEADER: begin
        fidx = hidx_nxt;
        if (is_digit) begin
          dec_nxt = (dec_mul > 20'hFFFF) ? 16'hFFFF : dec_mul[15:0];
        end else begin
          fv = dec_nxt;
          dec_nxt = '0;
          if (fv != 0 && fidx < 3'd4) begin
            unique case (fidx[1:0])
              2'd0: width_nxt = (fv > 16'(xid_pkg::MaxDim)) ? 11'(xid_pkg::MaxDim) : fv[10:0];
              2'd1: height_nxt = (fv > 16'(xid_pkg::MaxDim)) ? 11'(xid_pkg::MaxDim) : fv[10:0];
              2'd2: ccnt_nxt = (fv > 16'(xid_pkg::MaxColors)) ? 9'(xid_pkg::MaxColors) : fv[8:0];
              default: klen_nxt = (fv > 16'(xid_pkg::MaxKeyChars)) ? 2'(xid_pkg::MaxKeyChars) : fv[1:0];
            endcase
            fidx = fidx + 3'd1;
          end
        end
        if (line_end) begin
          fv = dec_nxt;
          dec_nxt = '0;
          if (fv != 0 && fidx < 3'd4) begin
            unique case (fidx[1:0])
              2'd0: width_nxt = (fv > 16'(xid_pkg::MaxDim)) ? 11'(xid_pkg::MaxDim) : fv[10:0];
              2'd1: height_nxt = (fv > 16'(xid_pkg::MaxDim)) ? 11'(xid_pkg::MaxDim) : fv[10:0];
              2'd2: ccnt_nxt = (fv > 16'(xid_pkg::MaxColors)) ? 9'(xid_pkg::MaxColors) : fv[8:0];
              default: klen_nxt = (fv > 16'(xid_pkg::MaxKeyChars)) ? 2'(xid_pkg::MaxKeyChars) : fv[1:0];
            endcase
            fidx = fidx + 3'd1;
          end
          lcnt_nxt = '0; pos_nxt = '0; kacc_nxt = '0; hex_nxt = '0;
          hdone_nxt = 1'b0; kfill_nxt = '0;
          if (ccnt_nxt != '0) phase_nxt = xid_pkg::PH_COLORS;
          else phase_nxt = (height_nxt == '0) ? xid_pkg::PH_DONE : xid_pkg::PH_PIXELS;
        end
        hidx_nxt = fidx;
      end
      xid_pkg::PH_COLORS: begin
        if (pos_r < {10'd0, cpp}) begin
          if (pos_r[0]) kacc_nxt[15:8] = kacc_r[15:8] | char_byte;
          else kacc_nxt[7:0] = kacc_r[7:0] | char_byte;
        end else if ({1'b0, pos_r} >= {11'd0, cpp} + 13'd4 && !hdone_r) begin
          if (!hexok) hdone_nxt = 1'b1;
          else hex_nxt = {hex_r[27:0], hexd};
        end
        if (pos_r < xid_pkg::PosMax) pos_nxt = pos_r + 1'b1;
        // The palette entry takes the key and color including this character.
        key_wr = kacc_nxt;
        hex_wr = hex_nxt;
        if (line_end) begin
          tbl_we = (lcnt_r < {2'b0, ccnt_r});
          lcnt_nxt = lcnt_r + 1'b1;
          pos_nxt = '0; kacc_nxt = '0; hex_nxt = '0; hdone_nxt = 1'b0; kfill_nxt = '0;
          if (lcnt_nxt >= {2'b0, ccnt_r}) begin
            lcnt_nxt = '0;
            phase_nxt = (height_r == '0) ? xid_pkg::PH_DONE : xid_pkg::PH_PIXELS;
          end
        end
      end
      xid_pkg::PH_PIXELS: begin
        if (kfill_r == 3'd0) kacc_nxt[7:0] = kacc_r[7:0] | char_byte;
        else if (kfill_r == 3'd1) kacc_nxt[15:8] = kacc_r[15:8] | char_byte;
        kfill_nxt = kfill_inc;
        if (kfill_inc >= {1'b0, cpp}) begin
          if (pos_r < xid_pkg::PosMax) pos_nxt = pos_r + 1'b1;
          kfill_nxt = '0; kacc_nxt = '0;
        end
        if (line_end) begin
          lcnt_nxt = lcnt_r + 1'b1;
          pos_nxt = '0; kacc_nxt = '0; hex_nxt = '0; hdone_nxt = 1'b0; kfill_nxt = '0;
          if (lcnt_nxt >= height_r) phase_nxt = xid_pkg::PH_DONE;
        end
      end
      default: ;
    endcase
  end

  // Configuration and parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0; origin_y_r <= '0;
      phase_r <= xid_pkg::PH_HEADER; hidx_r <= '0; dec_r <= '0;
      width_r <= '0; height_r <= '0; ccnt_r <= '0; klen_r <= '0;
      lcnt_r <= '0; pos_r <= '0; kacc_r <= '0; hex_r <= '0;
      hdone_r <= 1'b0; kfill_r <= '0;
    end else begin
      if (cfg_we && cfg_index == 1'b0) origin_x_r <= cfg_wdata;
      if (cfg_we && cfg_index == 1'b1) origin_y_r <= cfg_wdata;
      if (cmd.step) begin
        phase_r <= phase_nxt; hidx_r <= hidx_nxt; dec_r <= dec_nxt;
        width_r <= width_nxt; height_r <= height_nxt; ccnt_r <= ccnt_nxt;
        klen_r <= klen_nxt; lcnt_r <= lcnt_nxt; pos_r <= pos_nxt;
        kacc_r <= kacc_nxt; hex_r <= hex_nxt; hdone_r <= hdone_nxt;
        kfill_r <= kfill_nxt;
      end
    end
  end

  // Snapshot of the key being searched and its coordinates.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      ksrch_r <= (kfill_r == 3'd0) ? {kacc_r[15:8], kacc_r[7:0] | char_byte}
               : (kfill_r == 3'd1) ? {kacc_r[15:8] | char_byte, kacc_r[7:0]} : kacc_r;
      xsrch_r <= pos_r;
      ysrch_r <= lcnt_r;
    end
  end

  // Search index walks the table one entry at a time, on each search_inc.
  always_ff @(posedge clk) begin
    if (!rst_n) sidx_r <= '0;
    else if (cmd.search_clr) sidx_r <= '0;
    else if (cmd.search_inc) sidx_r <= sidx_r + 1'b1;
  end

  assign raddr = cmd.search_clr ? '0 : (cmd.search_inc ? sidx_r + 1'b1 : sidx_r);

  // Palette memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.step && tbl_we) begin
      key_mem[tbl_wa] <= key_wr;
      col_mem[tbl_wa] <= hex_wr;
    end
    key_rd <= key_mem[raddr];
    col_rd <= col_mem[raddr];
  end

  // Read data is valid in the cycle after the address settles.
  always_ff @(posedge clk) begin
    if (!rst_n) rd_ok_r <= 1'b0;
    else rd_ok_r <= !cmd.step && !cmd.search_inc;
  end

  assign sts.need_search = need_search;
  assign sts.hit         = rd_ok_r && (key_rd == ksrch_r);
  assign sts.search_end  = ({1'b0, sidx_r} + 9'd1 >= ccnt_r);

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_x     <= 13'(xsrch_r) + {{1{origin_x_r[11]}}, origin_x_r};
      pixel_y     <= {2'b0, ysrch_r} + {{1{origin_y_r[11]}}, origin_y_r};
      pixel_color <= col_rd;
      last_pixel  <= ({1'b0, xsrch_r} == {2'b0, width_r} - 13'd1) &&
                     (ysrch_r == height_r - 1'b1);
    end
  end
endmodule
`default_nettype wire

@@ rtl/xid_ctrl.sv @@
`default_nettype none
module xid_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  input  xid_pkg::xid_sts_t  sts,
  output xid_pkg::xid_cmd_t  cmd
);
  typedef enum logic [1:0] {S_IDLE, S_WAIT, S_SRCH} st_t;
  st_t st_r, st_nxt;
  logic out_valid_nxt;

  assign in_ready = (st_r == S_IDLE);

  always_comb begin
    st_nxt = st_r;
    out_valid_nxt = out_valid && !out_ready;
    cmd = '0;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step = 1'b1;
          cmd.search_clr = 1'b1;
          if (sts.need_search) st_nxt = S_WAIT;
        end
      end
      S_WAIT: st_nxt = S_SRCH;
      S_SRCH: begin
        if (sts.hit) begin
          if (!out_valid || out_ready) begin
            cmd.emit = 1'b1;
            out_valid_nxt = 1'b1;
            st_nxt = S_IDLE;
          end
        end else if (sts.search_end) begin
          st_nxt = S_IDLE;
        end else begin
          cmd.search_inc = 1'b1;
          st_nxt = S_WAIT;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/xpm_image_decoder_core.sv @@
// XPM image decoder core.
// Input channel in_*: one character per item with line-end and image-start
// flags. Output channel out_*: one pixel item for each pixel key that hits
// the palette, giving offset coordinates, color and a last-pixel flag.
// Configuration: cfg_we writes origin_x (index 0) or origin_y (index 1).
// Header and color-line characters start no search. A character that
// completes a pixel key starts a palette search in index order, first hit
// wins; each entry is read through the registered palette read and its wait
// state (S_WAIT, then S_SRCH), and no new character is accepted until the
// search ends. A full palette holds 256 entries.
// A hit is held in an output register; when the receiver stalls, the core
// waits with the hit until the previous item is taken, and accepts no new
// character meanwhile. A miss emits nothing.
// Reset (rst_n low, synchronous) returns to the header phase with origins
// zero; the palette memories are not cleared, since every entry is written
// before it can be searched.
`default_nettype none
module xpm_image_decoder_core (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire  [0:0]        cfg_index,
  input  wire  [11:0]       cfg_wdata,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [7:0]        in_char_byte,
  input  wire               in_line_end,
  input  wire               in_image_start,
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [12:0] out_pixel_x,
  output logic signed [12:0] out_pixel_y,
  output logic [31:0]       out_pixel_color,
  output logic              out_last_pixel
);
  xid_pkg::xid_cmd_t cmd;
  xid_pkg::xid_sts_t sts;

  // Sequencer.
  xid_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  // Parser, palette and output register.
  xid_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .char_byte(in_char_byte), .line_end(in_line_end),
    .image_start(in_image_start), .cmd, .sts,
    .pixel_x(out_pixel_x), .pixel_y(out_pixel_y),
    .pixel_color(out_pixel_color), .last_pixel(out_last_pixel)
  );
endmodule
`default_nettype wire

@@ rtl/xid_checker.sv @@
`default_nettype none
`include "xpm_image_decoder_core_defines.svh"
module xid_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_pixel_color
);
  // A waiting item stays offered.
  `XID_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out_valid dropped")
  // A stalled item keeps its color.
  `XID_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_pixel_color), "color changed")
  // An offered character stays offered until the core takes it.
  `XID_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid, "in_valid dropped")
  // The result valid drops only after its item has been taken.
  `XID_ASSERT_IMPLY(a_reset_out, clk, rst_n, $fell(out_valid), $past(out_ready), "out_valid fell untaken")
endmodule
bind xpm_image_decoder_core xid_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_pixel_color
);
`default_nettype wire
